// ----- rtl/ibalc_pkg.sv -----
// Shared types and codes for the inode block allocator.
`default_nettype none

package ibalc_pkg;

    localparam int NAME_W = 64;

    // command codes
    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_MAP    = 2'd2;
    localparam logic [1:0] OP_LIST   = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_INODE  = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_RANGE     = 3'd3;
    localparam logic [2:0] ST_NO_FILES  = 3'd4;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FREE_SCAN,
        S_ALLOC,
        S_CREATE_FIN,
        S_FIND_RD,
        S_FIND_CMP,
        S_DEL_RD,
        S_DEL_WR,
        S_MAP_RD,
        S_MAP_DONE,
        S_LIST_RD,
        S_LIST_CMP,
        S_EMIT
    } ibalc_state_t;

    typedef struct packed {
        logic set_used;
        logic clr_used;
    } itab_cmd_t;

    typedef struct packed {
        logic map_we;
        logic map_bit;
        logic ptr_we;
    } bstore_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/ibalc_inode_table.sv -----
// Inode table: in-use flags plus name and block count memories.
`default_nettype none

module ibalc_inode_table
    import ibalc_pkg::*;
#(
    parameter int NUM_INODES = 16,
    parameter int CNT_W      = 4,
    localparam int IW        = $clog2(NUM_INODES)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire itab_cmd_t         cmd,
    input  wire logic [IW-1:0]     wr_idx,
    input  wire logic [NAME_W-1:0] wr_name_high,
    input  wire logic [NAME_W-1:0] wr_name_low,
    input  wire logic [CNT_W-1:0]  wr_count,
    input  wire logic [IW-1:0]     rd_idx,
    output logic                   rd_used,
    output logic [NAME_W-1:0]      rd_name_high,
    output logic [NAME_W-1:0]      rd_name_low,
    output logic [CNT_W-1:0]       rd_count
);

    logic [NUM_INODES-1:0] in_use_reg;
    logic [2*NAME_W-1:0]   name_mem [NUM_INODES];
    logic [CNT_W-1:0]      count_mem [NUM_INODES];
    logic [2*NAME_W-1:0]   name_q;
    logic [CNT_W-1:0]      count_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
        end
        else
        begin
            if (cmd.set_used)
            begin
                in_use_reg[wr_idx] <= 1'b1;
            end
            else if (cmd.clr_used)
            begin
                in_use_reg[wr_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_used)
        begin
            name_mem[wr_idx]  <= {wr_name_high, wr_name_low};
            count_mem[wr_idx] <= wr_count;
        end
        name_q  <= name_mem[rd_idx];
        count_q <= count_mem[rd_idx];
    end

    assign rd_used      = in_use_reg[rd_idx];
    assign rd_name_high = name_q[2*NAME_W-1:NAME_W];
    assign rd_name_low  = name_q[NAME_W-1:0];
    assign rd_count     = count_q;

endmodule

`default_nettype wire

// ----- rtl/ibalc_block_store.sv -----
// Free-block bitmap and direct block pointer memories.
`default_nettype none

module ibalc_block_store
    import ibalc_pkg::*;
#(
    parameter int NUM_BLOCKS = 128,
    parameter int PTR_DEPTH  = 128,
    localparam int BW        = $clog2(NUM_BLOCKS),
    localparam int PAW       = $clog2(PTR_DEPTH)
)
(
    input  wire logic           clk,
    input  wire bstore_cmd_t    cmd,
    input  wire logic [BW-1:0]  map_waddr,
    input  wire logic [BW-1:0]  map_raddr,
    output logic                map_rdata,
    input  wire logic [PAW-1:0] ptr_waddr,
    input  wire logic [BW-1:0]  ptr_wdata,
    input  wire logic [PAW-1:0] ptr_raddr,
    output logic [BW-1:0]       ptr_rdata
);

    logic          map_mem [NUM_BLOCKS];
    logic [BW-1:0] ptr_mem [PTR_DEPTH];

    always_ff @(posedge clk)
    begin
        if (cmd.map_we)
        begin
            map_mem[map_waddr] <= cmd.map_bit;
        end
        map_rdata <= map_mem[map_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ptr_we)
        begin
            ptr_mem[ptr_waddr] <= ptr_wdata;
        end
        ptr_rdata <= ptr_mem[ptr_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/inode_block_allocator.sv -----
// Inode block allocator top level: command sequencer, scan counters and result register.
// One request at a time. Create scans the inodes one per cycle, then the bitmap one
// entry per cycle. Delete and map search the inodes by name; list walks all of them.
// After reset the bitmap is swept to free, with in_ready low.
`default_nettype none

module inode_block_allocator
    import ibalc_pkg::*;
#(
    parameter int NUM_INODES      = 16,
    parameter int NUM_BLOCKS      = 128,
    parameter int MAX_FILE_BLOCKS = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [63:0] name_high,
    input  wire logic [63:0] name_low,
    input  wire logic [3:0]  blocks_wanted,
    input  wire logic [2:0]  logical_block,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [3:0]       inode_index,
    output logic [3:0]       blocks_given,
    output logic [7:0]       physical_block,
    output logic [63:0]      out_name_high,
    output logic [63:0]      out_name_low,
    output logic             last
);

    localparam int IW        = $clog2(NUM_INODES);
    localparam int BW        = $clog2(NUM_BLOCKS);
    localparam int CW        = $clog2(MAX_FILE_BLOCKS + 1);
    localparam int PTR_DEPTH = NUM_INODES * MAX_FILE_BLOCKS;
    localparam int PAW       = $clog2(PTR_DEPTH);
    localparam int CMPW      = CW + 5;

    ibalc_state_t state_reg, state_next;

    logic [IW-1:0]     i_reg, i_next;
    logic [BW:0]       b_reg, b_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [BW-1:0]     pend_addr_reg, pend_addr_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     want_reg, want_next;
    logic [CW-1:0]     slot_reg, slot_next;
    logic [IW-1:0]     f_reg, f_next;
    logic [1:0]        op_reg, op_next;
    logic [NAME_W-1:0] nh_reg, nh_next;
    logic [NAME_W-1:0] nl_reg, nl_next;
    logic [2:0]        lb_reg, lb_next;

    logic [2:0]        res_status_reg, res_status_next;
    logic [3:0]        res_idx_reg, res_idx_next;
    logic [3:0]        res_given_reg, res_given_next;
    logic [7:0]        res_phys_reg, res_phys_next;
    logic [NAME_W-1:0] res_nh_reg, res_nh_next;
    logic [NAME_W-1:0] res_nl_reg, res_nl_next;
    logic              res_last_reg, res_last_next;
    logic              res_pend_reg, res_pend_next;

    logic              out_valid_reg, out_valid_next;
    logic [2:0]        out_status_reg, out_status_next;
    logic [3:0]        out_idx_reg, out_idx_next;
    logic [3:0]        out_given_reg, out_given_next;
    logic [7:0]        out_phys_reg, out_phys_next;
    logic [NAME_W-1:0] out_nh_reg, out_nh_next;
    logic [NAME_W-1:0] out_nl_reg, out_nl_next;
    logic              out_last_reg, out_last_next;

    itab_cmd_t         itab_cmd;
    logic              rd_used;
    logic [NAME_W-1:0] rd_name_high;
    logic [NAME_W-1:0] rd_name_low;
    logic [CW-1:0]     rd_count;

    bstore_cmd_t       bs_cmd;
    logic [BW-1:0]     map_waddr;
    logic              map_rdata;
    logic [PAW-1:0]    ptr_base;
    logic [PAW-1:0]    ptr_waddr;
    logic [PAW-1:0]    ptr_raddr;
    logic [BW-1:0]     ptr_rdata;

    logic              accept;
    logic              out_free;
    logic              i_last;
    logic              clear_last;
    logic              b_in_range;
    logic              pend_last;
    logic              alloc_hit;
    logic              alloc_done;
    logic              name_match;
    logic              lb_over;
    logic [CW-1:0]     want_sat;

    ibalc_inode_table #(
        .NUM_INODES (NUM_INODES),
        .CNT_W      (CW)
    ) u_itab (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (itab_cmd),
        .wr_idx       (f_reg),
        .wr_name_high (nh_reg),
        .wr_name_low  (nl_reg),
        .wr_count     (cnt_reg),
        .rd_idx       (i_reg),
        .rd_used      (rd_used),
        .rd_name_high (rd_name_high),
        .rd_name_low  (rd_name_low),
        .rd_count     (rd_count)
    );

    ibalc_block_store #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .PTR_DEPTH  (PTR_DEPTH)
    ) u_bstore (
        .clk       (clk),
        .cmd       (bs_cmd),
        .map_waddr (map_waddr),
        .map_raddr (b_reg[BW-1:0]),
        .map_rdata (map_rdata),
        .ptr_waddr (ptr_waddr),
        .ptr_wdata (pend_addr_reg),
        .ptr_raddr (ptr_raddr),
        .ptr_rdata (ptr_rdata)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign i_last     = (i_reg == IW'(NUM_INODES - 1));
    assign clear_last = (b_reg == (BW+1)'(NUM_BLOCKS - 1));
    assign b_in_range = (b_reg < (BW+1)'(NUM_BLOCKS));
    assign pend_last  = (pend_addr_reg == BW'(NUM_BLOCKS - 1));
    // bitmap data is registered, so it belongs to the previous read address; pend_* tracks that entry
    assign alloc_hit  = pend_valid_reg && !map_rdata && (cnt_reg != want_reg);
    assign alloc_done = (cnt_reg == want_reg) || (pend_valid_reg && pend_last);
    assign name_match = rd_used && (rd_name_high == nh_reg) && (rd_name_low == nl_reg);
    assign lb_over    = (CMPW'(lb_reg) >= CMPW'(rd_count));
    assign want_sat   = ({1'b0, blocks_wanted} > 5'(MAX_FILE_BLOCKS)) ?
                        CW'(MAX_FILE_BLOCKS) : CW'(blocks_wanted);

    assign ptr_base  = PAW'(f_reg) * PAW'(MAX_FILE_BLOCKS);
    assign ptr_waddr = ptr_base + PAW'(cnt_reg);
    assign ptr_raddr = ptr_base + PAW'(slot_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode) inside
                        OP_CREATE:        state_next = S_FREE_SCAN;
                        OP_DELETE, OP_MAP: state_next = S_FIND_RD;
                        OP_LIST:          state_next = S_LIST_RD;
                        default:          state_next = S_IDLE;
                    endcase
                end
            end
            S_FREE_SCAN:
            begin
                if (!rd_used)
                begin
                    state_next = S_ALLOC;
                end
                else if (i_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_ALLOC:
            begin
                if (alloc_done)
                begin
                    state_next = S_CREATE_FIN;
                end
            end
            S_CREATE_FIN: state_next = S_EMIT;
            S_FIND_RD:    state_next = S_FIND_CMP;
            S_FIND_CMP:
            begin
                if (name_match)
                begin
                    if (op_reg == OP_DELETE)
                    begin
                        state_next = S_DEL_RD;
                    end
                    else if (lb_over)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_MAP_RD;
                    end
                end
                else if (i_last)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_FIND_RD;
                end
            end
            S_DEL_RD:
            begin
                if (slot_reg == cnt_reg)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_DEL_WR;
                end
            end
            S_DEL_WR:   state_next = S_DEL_RD;
            S_MAP_RD:   state_next = S_MAP_DONE;
            S_MAP_DONE: state_next = S_EMIT;
            S_LIST_RD:  state_next = S_LIST_CMP;
            S_LIST_CMP:
            begin
                if ((rd_used && res_pend_reg) || i_last)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_LIST_RD;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = res_last_reg ? S_IDLE : S_LIST_CMP;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory commands
    always_comb
    begin
        i_next          = i_reg;
        b_next          = b_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        cnt_next        = cnt_reg;
        want_next       = want_reg;
        slot_next       = slot_reg;
        f_next          = f_reg;
        op_next         = op_reg;
        nh_next         = nh_reg;
        nl_next         = nl_reg;
        lb_next         = lb_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_given_next  = res_given_reg;
        res_phys_next   = res_phys_reg;
        res_nh_next     = res_nh_reg;
        res_nl_next     = res_nl_reg;
        res_last_next   = res_last_reg;
        res_pend_next   = res_pend_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_idx_next    = out_idx_reg;
        out_given_next  = out_given_reg;
        out_phys_next   = out_phys_reg;
        out_nh_next     = out_nh_reg;
        out_nl_next     = out_nl_reg;
        out_last_next   = out_last_reg;
        itab_cmd        = '0;
        bs_cmd          = '0;
        map_waddr       = b_reg[BW-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                bs_cmd.map_we  = 1'b1;
                bs_cmd.map_bit = 1'b0;
                b_next         = clear_last ? '0 : b_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next       = opcode;
                    nh_next       = name_high;
                    nl_next       = name_low;
                    want_next     = want_sat;
                    lb_next       = logical_block;
                    i_next        = '0;
                    res_pend_next = 1'b0;
                end
            end
            S_FREE_SCAN:
            begin
                if (!rd_used)
                begin
                    f_next          = i_reg;
                    b_next          = '0;
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                end
                else if (i_last)
                begin
                    res_status_next = ST_NO_INODE;
                    res_idx_next    = '0;
                    res_given_next  = '0;
                    res_phys_next   = '0;
                    res_nh_next     = '0;
                    res_nl_next     = '0;
                    res_last_next   = 1'b1;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_ALLOC:
            begin
                pend_valid_next = b_in_range;
                pend_addr_next  = b_reg[BW-1:0];
                if (b_in_range)
                begin
                    b_next = b_reg + 1'b1;
                end
                if (alloc_hit)
                begin
                    bs_cmd.map_we  = 1'b1;
                    bs_cmd.map_bit = 1'b1;
                    bs_cmd.ptr_we  = 1'b1;
                    map_waddr      = pend_addr_reg;
                    cnt_next       = cnt_reg + 1'b1;
                end
            end
            S_CREATE_FIN:
            begin
                itab_cmd.set_used = 1'b1;
                res_status_next   = ST_OK;
                res_idx_next      = 4'(f_reg);
                res_given_next    = 4'(cnt_reg);
                res_phys_next     = '0;
                res_nh_next       = '0;
                res_nl_next       = '0;
                res_last_next     = 1'b1;
            end
            S_FIND_CMP:
            begin
                if (name_match)
                begin
                    f_next    = i_reg;
                    cnt_next  = rd_count;
                    slot_next = (op_reg == OP_DELETE) ? '0 : CW'(lb_reg);
                    if (op_reg != OP_DELETE && lb_over)
                    begin
                        res_status_next = ST_RANGE;
                        res_idx_next    = 4'(i_reg);
                        res_given_next  = 4'(rd_count);
                        res_phys_next   = '0;
                        res_nh_next     = '0;
                        res_nl_next     = '0;
                        res_last_next   = 1'b1;
                    end
                end
                else if (i_last)
                begin
                    res_status_next = ST_NOT_FOUND;
                    res_idx_next    = '0;
                    res_given_next  = '0;
                    res_phys_next   = '0;
                    res_nh_next     = '0;
                    res_nl_next     = '0;
                    res_last_next   = 1'b1;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_DEL_RD:
            begin
                if (slot_reg == cnt_reg)
                begin
                    itab_cmd.clr_used = 1'b1;
                    res_status_next   = ST_OK;
                    res_idx_next      = 4'(f_reg);
                    res_given_next    = 4'(cnt_reg);
                    res_phys_next     = '0;
                    res_nh_next       = '0;
                    res_nl_next       = '0;
                    res_last_next     = 1'b1;
                end
            end
            S_DEL_WR:
            begin
                bs_cmd.map_we  = 1'b1;
                bs_cmd.map_bit = 1'b0;
                map_waddr      = ptr_rdata;
                slot_next      = slot_reg + 1'b1;
            end
            S_MAP_DONE:
            begin
                res_status_next = ST_OK;
                res_idx_next    = 4'(f_reg);
                res_given_next  = 4'(cnt_reg);
                res_phys_next   = 8'(ptr_rdata) + 8'd1;
                res_nh_next     = '0;
                res_nl_next     = '0;
                res_last_next   = 1'b1;
            end
            S_LIST_CMP:
            begin
                if (rd_used && res_pend_reg)
                begin
                    // flush the held entry first; this inode is looked at again
                    res_last_next = 1'b0;
                end
                else
                begin
                    if (rd_used)
                    begin
                        res_status_next = ST_OK;
                        res_idx_next    = 4'(i_reg);
                        res_given_next  = 4'(rd_count);
                        res_phys_next   = '0;
                        res_nh_next     = rd_name_high;
                        res_nl_next     = rd_name_low;
                        res_pend_next   = 1'b1;
                        res_last_next   = i_last;
                    end
                    else if (i_last)
                    begin
                        res_last_next = 1'b1;
                        if (!res_pend_reg)
                        begin
                            res_status_next = ST_NO_FILES;
                            res_idx_next    = '0;
                            res_given_next  = '0;
                            res_phys_next   = '0;
                            res_nh_next     = '0;
                            res_nl_next     = '0;
                        end
                    end
                    if (!i_last)
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_idx_next    = res_idx_reg;
                    out_given_next  = res_given_reg;
                    out_phys_next   = res_phys_reg;
                    out_nh_next     = res_nh_reg;
                    out_nl_next     = res_nl_reg;
                    out_last_next   = res_last_reg;
                    res_pend_next   = 1'b0;
                end
            end
            default:
            begin
                i_next = i_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            i_reg          <= '0;
            b_reg          <= '0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            slot_reg       <= '0;
            res_pend_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            i_reg          <= i_next;
            b_reg          <= b_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            slot_reg       <= slot_next;
            res_pend_reg   <= res_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg  <= pend_addr_next;
        want_reg       <= want_next;
        f_reg          <= f_next;
        op_reg         <= op_next;
        nh_reg         <= nh_next;
        nl_reg         <= nl_next;
        lb_reg         <= lb_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_given_reg  <= res_given_next;
        res_phys_reg   <= res_phys_next;
        res_nh_reg     <= res_nh_next;
        res_nl_reg     <= res_nl_next;
        res_last_reg   <= res_last_next;
        out_status_reg <= out_status_next;
        out_idx_reg    <= out_idx_next;
        out_given_reg  <= out_given_next;
        out_phys_reg   <= out_phys_next;
        out_nh_reg     <= out_nh_next;
        out_nl_reg     <= out_nl_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign inode_index    = out_idx_reg;
    assign blocks_given   = out_given_reg;
    assign physical_block = out_phys_reg;
    assign out_name_high  = out_nh_reg;
    assign out_name_low   = out_nl_reg;
    assign last           = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/ibalc_checker.sv -----
// Port-level checks for the inode block allocator, bound to the top level.
`default_nettype none

module ibalc_checker
    import ibalc_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  status,
    input wire logic [3:0]  inode_index,
    input wire logic [3:0]  blocks_given,
    input wire logic [7:0]  physical_block,
    input wire logic [63:0] out_name_high,
    input wire logic [63:0] out_name_low,
    input wire logic        last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(inode_index)
            && $stable(blocks_given) && $stable(physical_block) && $stable(last))
        else $error("result changed while stalled");

    // one request in flight: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

    // any error ends the request and carries no block or name
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> last && physical_block == 8'd0
            && out_name_high == 64'd0 && out_name_low == 64'd0)
        else $error("error result malformed");

    // a mapped block comes only in a single ok result
    a_phys_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && physical_block != 8'd0 |-> status == ST_OK && last
            && out_name_high == 64'd0 && out_name_low == 64'd0)
        else $error("mapped block in wrong result");

    // no file behind the result: index and count read zero
    a_no_file: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NO_INODE || status == ST_NOT_FOUND
            || status == ST_NO_FILES) |-> inode_index == 4'd0 && blocks_given == 4'd0)
        else $error("fileless result has index or count");

endmodule

bind inode_block_allocator ibalc_checker u_ibalc_checker (.*);

`default_nettype wire
